// ----- rtl/tbeg_pkg.sv -----
// Shared types, constants and a helper function of the touch and button event generator.
`default_nettype none

package tbeg_pkg;

	// Field widths. The magnitude width covers a 12-bit raw difference times a screen size
	// of up to 1024.
	localparam int RAW_W      = 12;
	localparam int DEN_W      = RAW_W + 1;
	localparam int SIZE_W     = 12;
	localparam int PROD_W     = DEN_W + SIZE_W;
	localparam int MAG_W      = 22;
	localparam int NUM_W      = MAG_W + 1;
	localparam int PT_W       = 9;
	localparam int CODE_W     = 4;
	localparam int SAMPLE_W   = 24;
	localparam int NUM_BTN    = 8;
	localparam int BTN_IDX_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [BTN_IDX_W-1:0] BTN_LAST = BTN_IDX_W'(NUM_BTN - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MAX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX  = 3'd4;

	// Reset values of the calibration registers.
	localparam logic [RAW_W-1:0] X_MIN_RST = 12'd220;
	localparam logic [RAW_W-1:0] X_MAX_RST = 12'd3900;
	localparam logic [RAW_W-1:0] Y_MIN_RST = 12'd160;
	localparam logic [RAW_W-1:0] Y_MAX_RST = 12'd3950;

	// Screen orientations.
	localparam logic [1:0] ORIENT_VERT       = 2'd0;
	localparam logic [1:0] ORIENT_HORIZ      = 2'd1;
	localparam logic [1:0] ORIENT_VERT_MIRR  = 2'd2;
	localparam logic [1:0] ORIENT_HORIZ_MIRR = 2'd3;

	// Event codes.
	localparam logic [CODE_W-1:0] EVT_BTN_A      = 4'd0;
	localparam logic [CODE_W-1:0] EVT_BTN_B      = 4'd1;
	localparam logic [CODE_W-1:0] EVT_BTN_C      = 4'd2;
	localparam logic [CODE_W-1:0] EVT_BTN_JOY    = 4'd3;
	localparam logic [CODE_W-1:0] EVT_BTN_UP     = 4'd4;
	localparam logic [CODE_W-1:0] EVT_BTN_DOWN   = 4'd5;
	localparam logic [CODE_W-1:0] EVT_BTN_LEFT   = 4'd6;
	localparam logic [CODE_W-1:0] EVT_BTN_RIGHT  = 4'd7;
	localparam logic [CODE_W-1:0] EVT_TOUCH_DOWN = 4'd8;
	localparam logic [CODE_W-1:0] EVT_TOUCH_MOVE = 4'd9;
	localparam logic [CODE_W-1:0] EVT_TOUCH_UP   = 4'd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BTN,
		ST_TOUCH,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ROT,
		ST_TEVT,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [1:0]       orient;
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
	} cfg_t;

	// One poll tick with button levels already normalized to 1 = pressed,
	// in scan order a, b, c, joy, down, left, right, up.
	typedef struct packed {
		logic [NUM_BTN-1:0]  levels;
		logic                touch_active;
		logic [SAMPLE_W-1:0] sample;
	} tick_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              dir;
		logic [PT_W-1:0]   x;
		logic [PT_W-1:0]   y;
		logic              last;
	} evt_t;

	typedef struct packed {
		logic valid;
		evt_t evt;
	} evt_push_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             neg;
		logic [MAG_W-1:0] quot;
	} div_rsp_t;

	// Event code of the button at a given scan position.
	function automatic logic [CODE_W-1:0] btn_code(input logic [BTN_IDX_W-1:0] idx);
		logic [CODE_W-1:0] c;
		unique case (idx)
			3'd0:    c = EVT_BTN_A;
			3'd1:    c = EVT_BTN_B;
			3'd2:    c = EVT_BTN_C;
			3'd3:    c = EVT_BTN_JOY;
			3'd4:    c = EVT_BTN_DOWN;
			3'd5:    c = EVT_BTN_LEFT;
			3'd6:    c = EVT_BTN_RIGHT;
			default: c = EVT_BTN_UP;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tbeg_in_if.sv -----
// Poll tick channel: valid/ready handshake with the button levels and the touch sample.
`default_nettype none

interface tbeg_in_if;
	logic        valid;
	logic        ready;
	logic        key_pin;
	logic        tamper_pin;
	logic        wakeup_pin;
	logic [7:0]  expander_pins;
	logic        touch_active;
	logic [23:0] touch_sample;

	modport source (
		output valid, key_pin, tamper_pin, wakeup_pin, expander_pins, touch_active,
		touch_sample,
		input  ready
	);
	modport sink (
		input  valid, key_pin, tamper_pin, wakeup_pin, expander_pins, touch_active,
		touch_sample,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/tbeg_out_if.sv -----
// Event channel: valid/ready handshake with one button or touch event.
`default_nettype none

interface tbeg_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_code;
	logic       direction;
	logic [8:0] point_x;
	logic [8:0] point_y;
	logic       last;

	modport source (
		output valid, event_code, direction, point_x, point_y, last,
		input  ready
	);
	modport sink (
		input  valid, event_code, direction, point_x, point_y, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/tbeg_div.sv -----
// Shared restoring divider, one quotient bit per cycle, signed operands, result in sign-magnitude.
`default_nettype none

module tbeg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tbeg_pkg::div_req_t req,
	output tbeg_pkg::div_rsp_t rsp
);
	import tbeg_pkg::*;

	localparam int CNT_W = $clog2(MAG_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [MAG_W-1:0] quo_q;
	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] den_q;

	logic [NUM_W-1:0] num_abs;
	logic [DEN_W-1:0] den_abs;
	logic [RAW_W:0]   rem_sh;
	logic [RAW_W:0]   rem_sub;
	logic             q_bit;

	always_comb begin
		num_abs = req.num[NUM_W-1] ? (~req.num + NUM_W'(1)) : req.num;
		den_abs = req.den[DEN_W-1] ? (~req.den + DEN_W'(1)) : req.den;
		rem_sh  = {rem_q, quo_q[MAG_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		q_bit   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			den_q <= den_abs[RAW_W-1:0];
			neg_q <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.quot = quo_q;

endmodule

`default_nettype wire

// ----- rtl/tbeg_seq.sv -----
// Sequencer: button scan, touch calibration through the shared divider, and event ordering.
`default_nettype none

module tbeg_seq #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tbeg_pkg::tick_t     tick,
	input  tbeg_pkg::cfg_t      cfg,
	input  logic                out_free,
	output logic                idle,
	output tbeg_pkg::evt_push_t push,
	output tbeg_pkg::div_req_t  div_req,
	input  tbeg_pkg::div_rsp_t  div_rsp
);
	import tbeg_pkg::*;

	localparam int MAX_SIZE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int CW = $clog2(MAX_SIZE);
	localparam logic [CW-1:0] W_MAX = CW'(SCREEN_WIDTH - 1);
	localparam logic [CW-1:0] H_MAX = CW'(SCREEN_HEIGHT - 1);
	localparam logic [MAG_W-1:0] W_LIM = MAG_W'(SCREEN_WIDTH - 1);
	localparam logic [MAG_W-1:0] H_LIM = MAG_W'(SCREEN_HEIGHT - 1);
	localparam logic signed [PROD_W-1:0] W_S = PROD_W'(SCREEN_WIDTH);
	localparam logic signed [PROD_W-1:0] H_S = PROD_W'(SCREEN_HEIGHT);

	seq_state_t state_q, state_d;

	logic [NUM_BTN-1:0]      lv_q;
	logic [NUM_BTN-1:0]      pressed_q;
	logic                    touch_act_q;
	logic [SAMPLE_W-1:0]     sample_q;
	logic [BTN_IDX_W-1:0]    idx_q;
	logic                    axis_q;
	logic                    armed_q;
	logic                    was_down_q;
	logic                    have_pt_q;
	logic [CW-1:0]           last_x_q, last_y_q;
	logic [CW-1:0]           sc_x_q, sc_y_q;
	logic [CW-1:0]           pt_x_q, pt_y_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [DEN_W-1:0] den_q;
	logic                    pend_valid_q;
	evt_t                    pend_q;

	logic [CODE_W-1:0]        code;
	logic                     btn_chg;
	logic                     can_emit;
	logic [RAW_W-1:0]         raw_v, lo, hi;
	logic signed [DEN_W-1:0]  diff_c, den_c;
	logic signed [PROD_W-1:0] size_c, prod;
	logic [MAG_W-1:0]         lim, clamp_q;
	logic [CW-1:0]            clamp_v;
	logic [CW-1:0]            rot_x, rot_y;
	logic                     touch_need;
	logic                     den_zero;
	logic                     axis_end;
	logic                     new_evt;
	logic                     advance;
	evt_t                     nevt;

	// Datapath shared by both axes; axis_q selects X or Y.
	always_comb begin
		code     = btn_code(idx_q);
		btn_chg  = lv_q[idx_q] != pressed_q[code[BTN_IDX_W-1:0]];
		can_emit = !pend_valid_q || out_free;

		raw_v  = axis_q ? ~sample_q[RAW_W-1:0] : sample_q[SAMPLE_W-1:RAW_W];
		lo     = axis_q ? cfg.y_min : cfg.x_min;
		hi     = axis_q ? cfg.y_max : cfg.x_max;
		size_c = axis_q ? H_S : W_S;
		diff_c = $signed({1'b0, raw_v}) - $signed({1'b0, lo});
		den_c  = $signed({1'b0, hi}) - $signed({1'b0, lo});
		prod   = PROD_W'(diff_c) * size_c;

		// A negative quotient clamps to zero, a large one to the far edge.
		lim     = axis_q ? H_LIM : W_LIM;
		clamp_q = div_rsp.neg ? '0 : ((div_rsp.quot > lim) ? lim : div_rsp.quot);
		clamp_v = clamp_q[CW-1:0];

		den_zero = (den_q == '0);
		axis_end = (state_q == ST_DIV_START && den_zero) ||
		           (state_q == ST_DIV_WAIT && div_rsp.done);

		unique case (cfg.orient)
			ORIENT_VERT: begin
				rot_x = sc_x_q;
				rot_y = sc_y_q;
			end
			ORIENT_HORIZ: begin
				rot_x = H_MAX - sc_y_q;
				rot_y = sc_x_q;
			end
			ORIENT_VERT_MIRR: begin
				rot_x = W_MAX - sc_x_q;
				rot_y = H_MAX - sc_y_q;
			end
			default: begin
				rot_x = sc_y_q;
				rot_y = W_MAX - sc_x_q;
			end
		endcase

		if (have_pt_q) begin
			touch_need = !was_down_q || (pt_x_q != last_x_q) || (pt_y_q != last_y_q);
		end else begin
			touch_need = was_down_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_BTN;
			end
			ST_BTN: begin
				if (advance && idx_q == BTN_LAST) state_d = ST_TOUCH;
			end
			ST_TOUCH: begin
				state_d = (touch_act_q && armed_q) ? ST_MUL : ST_TEVT;
			end
			ST_MUL: begin
				state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				if (den_zero) state_d = axis_q ? ST_ROT : ST_MUL;
				else state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) state_d = axis_q ? ST_ROT : ST_MUL;
			end
			ST_ROT: begin
				state_d = ST_TEVT;
			end
			ST_TEVT: begin
				if (advance) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (advance) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs. A new event goes into the pending slot; whatever was pending moves out
	// with last clear. The pending event left at the end goes out with last set.
	always_comb begin
		idle          = (state_q == ST_IDLE);
		new_evt       = 1'b0;
		advance       = 1'b1;
		nevt          = '0;
		push          = '0;
		div_req.start = 1'b0;
		div_req.num   = num_q;
		div_req.den   = den_q;
		unique case (state_q)
			ST_BTN: begin
				new_evt   = btn_chg && can_emit;
				advance   = !btn_chg || can_emit;
				nevt.code = code;
				nevt.dir  = ~lv_q[idx_q];
			end
			ST_DIV_START: begin
				div_req.start = !den_zero;
			end
			ST_DIV_WAIT: begin
				advance = div_rsp.done;
			end
			ST_TEVT: begin
				new_evt = touch_need && can_emit;
				advance = !touch_need || can_emit;
				if (have_pt_q) begin
					nevt.code = was_down_q ? EVT_TOUCH_MOVE : EVT_TOUCH_DOWN;
					nevt.dir  = 1'b0;
					nevt.x    = PT_W'(pt_x_q);
					nevt.y    = PT_W'(pt_y_q);
				end else begin
					nevt.code = EVT_TOUCH_UP;
					nevt.dir  = 1'b1;
					nevt.x    = PT_W'(last_x_q);
					nevt.y    = PT_W'(last_y_q);
				end
			end
			ST_FLUSH: begin
				advance       = !pend_valid_q || out_free;
				push.valid    = pend_valid_q && out_free;
				push.evt      = pend_q;
				push.evt.last = 1'b1;
			end
			default: ;
		endcase
		if (new_evt && pend_valid_q) begin
			push.valid    = 1'b1;
			push.evt      = pend_q;
			push.evt.last = 1'b0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			axis_q       <= 1'b0;
			pressed_q    <= '0;
			armed_q      <= 1'b0;
			was_down_q   <= 1'b0;
			have_pt_q    <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				idx_q  <= '0;
				axis_q <= 1'b0;
			end
			if (state_q == ST_BTN && advance) begin
				idx_q <= idx_q + BTN_IDX_W'(1);
				if (btn_chg) pressed_q[code[BTN_IDX_W-1:0]] <= lv_q[idx_q];
			end
			if (state_q == ST_TOUCH) begin
				have_pt_q <= 1'b0;
				if (!touch_act_q) armed_q <= 1'b0;
				else armed_q <= 1'b1;
			end
			if (axis_end) axis_q <= 1'b1;
			if (state_q == ST_ROT) have_pt_q <= 1'b1;
			if (state_q == ST_TEVT && advance) begin
				was_down_q <= have_pt_q;
				if (have_pt_q && touch_need) begin
					last_x_q <= pt_x_q;
					last_y_q <= pt_y_q;
				end
			end
			if (new_evt) pend_valid_q <= 1'b1;
			else if (state_q == ST_FLUSH && push.valid) pend_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			lv_q        <= tick.levels;
			touch_act_q <= tick.touch_active;
			sample_q    <= tick.sample;
		end
		if (state_q == ST_MUL) begin
			num_q <= prod[NUM_W-1:0];
			den_q <= den_c;
		end
		if (axis_end) begin
			if (axis_q) sc_y_q <= (state_q == ST_DIV_WAIT) ? clamp_v : '0;
			else sc_x_q <= (state_q == ST_DIV_WAIT) ? clamp_v : '0;
		end
		if (state_q == ST_ROT) begin
			pt_x_q <= rot_x;
			pt_y_q <= rot_y;
		end
		if (new_evt) pend_q <= nevt;
	end

endmodule

`default_nettype wire

// ----- rtl/touch_and_button_event_generator_core.sv -----
// Top level of the touch and button event generator: configuration, sequencer, divider, output.
// A tick with a touch point runs the bit-serial divider for each axis with a nonzero calibration
// span, X first and then Y. Output back-pressure stalls the sequencer until its event can move out.
// Throughput: one tick at a time; in_ch.ready is high only while the sequencer is idle.
// Reset (arst_n low, asynchronous) restores the calibration defaults and clears all
// button, touch and output state.
`default_nettype none

module touch_and_button_event_generator_core #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                               clk,
	input  logic                               arst_n,
	tbeg_in_if.sink                            in_ch,
	tbeg_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [tbeg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbeg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import tbeg_pkg::*;

	cfg_t      cfg_q;
	tick_t     tick;
	logic      start;
	logic      idle;
	logic      out_free;
	evt_push_t push;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	logic      out_valid_q;
	evt_t      out_evt_q;

	// Configuration registers. Writes to indexes beyond the list are dropped. The user must keep
	// the block only reconfigured while idle, so no shadowing is needed; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orient <= ORIENT_VERT;
			cfg_q.x_min  <= X_MIN_RST;
			cfg_q.x_max  <= X_MAX_RST;
			cfg_q.y_min  <= Y_MIN_RST;
			cfg_q.y_max  <= Y_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIENT: cfg_q.orient <= cfg_wdata[1:0];
				CFG_X_MIN:  cfg_q.x_min  <= cfg_wdata[RAW_W-1:0];
				CFG_X_MAX:  cfg_q.x_max  <= cfg_wdata[RAW_W-1:0];
				CFG_Y_MIN:  cfg_q.y_min  <= cfg_wdata[RAW_W-1:0];
				CFG_Y_MAX:  cfg_q.y_max  <= cfg_wdata[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	// Normalize all eight button levels to 1 = pressed, in scan order
	// a, b, c, joy, down, left, right, up. The key, tamper and expander pins are
	// active low; the wakeup pin is active high. Expander bits 2..0 are unused.
	always_comb begin
		tick.levels       = {~in_ch.expander_pins[3], ~in_ch.expander_pins[4],
		                     ~in_ch.expander_pins[5], ~in_ch.expander_pins[6],
		                     ~in_ch.expander_pins[7], in_ch.wakeup_pin,
		                     ~in_ch.tamper_pin, ~in_ch.key_pin};
		tick.touch_active = in_ch.touch_active;
		tick.sample       = in_ch.touch_sample;
	end

	// A tick transaction is taken only when the sequencer has finished the previous one.
	assign in_ch.ready = idle;
	assign start       = in_ch.valid && idle;

	// The output register frees up in the same cycle that the consumer takes its event,
	// so events stream out back to back when the consumer keeps ready high.
	assign out_free = !out_valid_q || out_ch.ready;

	tbeg_seq #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.tick     (tick),
		.cfg      (cfg_q),
		.out_free (out_free),
		.idle     (idle),
		.push     (push),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	// One divider serves both calibration axes, X first and then Y.
	tbeg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register. The sequencer pushes only when out_free is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) out_evt_q <= push.evt;
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.event_code = out_evt_q.code;
	assign out_ch.direction  = out_evt_q.dir;
	assign out_ch.point_x    = out_evt_q.x;
	assign out_ch.point_y    = out_evt_q.y;
	assign out_ch.last       = out_evt_q.last;

endmodule

`default_nettype wire

// ----- rtl/tbeg_chk.sv -----
// Port-level checker for the touch and button event generator, bound to the top level.
`default_nettype none

module tbeg_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_code,
	input logic       out_dir,
	input logic [8:0] out_x,
	input logic [8:0] out_y,
	input logic       out_last
);
	import tbeg_pkg::*;

	// A waiting event must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_dir) &&
		$stable(out_x) && $stable(out_y) && $stable(out_last))
		else $error("event changed while stalled");

	// Once a tick is taken, the block is busy and drops ready.
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a tick was taken");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_code <= EVT_TOUCH_UP)
		else $error("event code out of range");

	a_button_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_code < EVT_TOUCH_DOWN |-> out_x == 9'd0 && out_y == 9'd0)
		else $error("button event carries a point");

	// Touch down and move are presses; touch up is a release.
	a_touch_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_code >= EVT_TOUCH_DOWN |-> out_dir == (out_code == EVT_TOUCH_UP))
		else $error("touch event has wrong direction");

endmodule

bind touch_and_button_event_generator_core tbeg_chk u_tbeg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_code  (out_ch.event_code),
	.out_dir   (out_ch.direction),
	.out_x     (out_ch.point_x),
	.out_y     (out_ch.point_y),
	.out_last  (out_ch.last)
);

`default_nettype wire

// ----- verif/tbeg_event_checker.sv -----
// Event checker: watches both channels and the register port, predicts the events and compares.
`timescale 1ns / 1ps

module tbeg_event_checker
	import tbeg_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tbeg_in_if                    in_mon,
	tbeg_out_if                   out_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    error_count,
	output int                    pending
);

	// Event code of each button in scan order.
	localparam logic [CODE_W-1:0] SCAN_CODE [NUM_BTN] = '{
		EVT_BTN_A, EVT_BTN_B, EVT_BTN_C, EVT_BTN_JOY,
		EVT_BTN_DOWN, EVT_BTN_LEFT, EVT_BTN_RIGHT, EVT_BTN_UP
	};

	cfg_t              cal;
	logic [NUM_BTN-1:0] pressed;        // indexed by event code
	logic              touch_armed;
	logic              touch_down;
	logic [PT_W-1:0]   last_x;
	logic [PT_W-1:0]   last_y;
	evt_t              expected_events[$];
	evt_t              want;

	function automatic int scale_coord(int raw, int lo, int hi, int size);
		int den;
		int r;
		den = hi - lo;
		r   = 0;
		if (den != 0)
			r = ((raw - lo) * size) / den;
		if (r < 0)
			r = 0;
		if (r > size - 1)
			r = size - 1;
		return r;
	endfunction

	function automatic evt_t make_evt(logic [CODE_W-1:0] code, logic dir, int x, int y);
		evt_t e;
		e.code = code;
		e.dir  = dir;
		e.x    = PT_W'(x);
		e.y    = PT_W'(y);
		e.last = 1'b0;
		return e;
	endfunction

	// Works out every event one poll tick causes and queues them in order.
	task automatic predict_tick(input logic [NUM_BTN-1:0] levels, input logic active,
			input logic [SAMPLE_W-1:0] sample);
		evt_t tick_events[$];
		int   sx;
		int   sy;
		int   px;
		int   py;
		logic have_pt;
		have_pt = 1'b0;
		px      = 0;
		py      = 0;
		for (int i = 0; i < NUM_BTN; i++) begin
			if (levels[i] != pressed[SCAN_CODE[i]]) begin
				tick_events.push_back(make_evt(SCAN_CODE[i], !levels[i], 0, 0));
				pressed[SCAN_CODE[i]] = levels[i];
			end
		end
		if (!active) begin
			touch_armed = 1'b0;
		end else if (!touch_armed) begin
			touch_armed = 1'b1;
		end else begin
			sx = scale_coord(int'(sample[23:12]), int'(cal.x_min), int'(cal.x_max), SCREEN_WIDTH);
			sy = scale_coord(4095 - int'(sample[11:0]), int'(cal.y_min), int'(cal.y_max),
				SCREEN_HEIGHT);
			case (cal.orient)
				ORIENT_VERT: begin
					px = sx;
					py = sy;
				end
				ORIENT_HORIZ: begin
					px = (SCREEN_HEIGHT - 1) - sy;
					py = sx;
				end
				ORIENT_VERT_MIRR: begin
					px = (SCREEN_WIDTH - 1) - sx;
					py = (SCREEN_HEIGHT - 1) - sy;
				end
				default: begin
					px = sy;
					py = (SCREEN_WIDTH - 1) - sx;
				end
			endcase
			have_pt = 1'b1;
		end
		if (have_pt) begin
			if (!touch_down || PT_W'(px) != last_x || PT_W'(py) != last_y) begin
				last_x = PT_W'(px);
				last_y = PT_W'(py);
				tick_events.push_back(make_evt(touch_down ? EVT_TOUCH_MOVE : EVT_TOUCH_DOWN,
					1'b0, px, py));
			end
			touch_down = 1'b1;
		end else begin
			if (touch_down)
				tick_events.push_back(make_evt(EVT_TOUCH_UP, 1'b1, int'(last_x), int'(last_y)));
			touch_down = 1'b0;
		end
		if (tick_events.size() > 0)
			tick_events[tick_events.size() - 1].last = 1'b1;
		foreach (tick_events[k])
			expected_events.push_back(tick_events[k]);
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal.orient  = ORIENT_VERT;
			cal.x_min   = X_MIN_RST;
			cal.x_max   = X_MAX_RST;
			cal.y_min   = Y_MIN_RST;
			cal.y_max   = Y_MAX_RST;
			pressed     = '0;
			touch_armed = 1'b0;
			touch_down  = 1'b0;
			last_x      = '0;
			last_y      = '0;
			error_count = 0;
			expected_events.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIENT: cal.orient = cfg_wdata[1:0];
					CFG_X_MIN:  cal.x_min  = cfg_wdata[RAW_W-1:0];
					CFG_X_MAX:  cal.x_max  = cfg_wdata[RAW_W-1:0];
					CFG_Y_MIN:  cal.y_min  = cfg_wdata[RAW_W-1:0];
					CFG_Y_MAX:  cal.y_max  = cfg_wdata[RAW_W-1:0];
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: code %0d direction %0d point %0d,%0d last %0d",
						out_mon.event_code, out_mon.direction, out_mon.point_x,
						out_mon.point_y, out_mon.last);
					error_count++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_code", want.code, out_mon.event_code);
					check_field("direction", want.dir, out_mon.direction);
					check_field("point_x", want.x, out_mon.point_x);
					check_field("point_y", want.y, out_mon.point_y);
					check_field("last", want.last, out_mon.last);
				end
			end
			if (in_mon.valid && in_mon.ready)
				predict_tick({~in_mon.expander_pins[3], ~in_mon.expander_pins[4],
					~in_mon.expander_pins[5], ~in_mon.expander_pins[6],
					~in_mon.expander_pins[7], in_mon.wakeup_pin, ~in_mon.tamper_pin,
					~in_mon.key_pin}, in_mon.touch_active, in_mon.touch_sample);
		end
		pending = expected_events.size();
	end

endmodule

// ----- verif/tb_touch_and_button_event_generator_core.sv -----
// Testbench top: clock, reset, poll tick stimulus, register writes and the final verdict.
`timescale 1ns / 1ps

module tb_touch_and_button_event_generator_core;
	import tbeg_pkg::*;

	// A tick that causes no event may still be in flight when the last expected event has
	// arrived, so register writes and the end of the run wait SETTLE_CYCLES after the event
	// queue has drained.
	localparam int SETTLE_CYCLES = 100;
	// Length of the deliberate receiver hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES   = 400;
	// Generous bound on the whole run, several times the slowest legal run.
	localparam int CYCLE_LIMIT   = 600000;
	localparam int NUM_PHASES    = 8;
	localparam int TICKS_PER_PHASE = 60;

	// Pin vectors are {key, tamper, wakeup, expander[7:0]}.
	localparam logic [10:0] PINS_RELEASED = {1'b1, 1'b1, 1'b0, 8'hFF};
	localparam logic [10:0] PINS_ALL_DOWN = {1'b0, 1'b0, 1'b1, 8'h00};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    pending;
	int                    cycle_count;

	// Knobs shared between the stimulus and the receiver.
	bit in_idle_on;
	bit out_idle_on;
	bit hold_req;

	// Random stimulus state: current pin levels and the shape of the touch gesture.
	logic [10:0] pins;
	int          touch_run;
	int          touch_gap;
	logic [23:0] last_sample;

	tbeg_in_if  in_ch ();
	tbeg_out_if out_ch ();

	touch_and_button_event_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tbeg_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.error_count (fail_count),
		.pending     (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: if the run has not ended by the limit, something is stuck.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver. Normally it drops ready at random while out_idle_on is set; when a hold-off is
	// requested it keeps ready low for HOLD_CYCLES so that the block backs up into its input.
	initial begin
		int hold_count;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_req = 1'b0;
			end else begin
				out_ch.ready <= !(out_idle_on && $urandom_range(99) < 36);
			end
		end
	end

	// Offers one poll tick and returns at the edge where the transaction is accepted.
	// Valid is left high afterwards, so back-to-back ticks never toggle it within a step.
	task automatic send_tick(input logic [10:0] p, input logic active, input logic [23:0] sample);
		while (in_idle_on && $urandom_range(99) < 36) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.key_pin       <= p[10];
		in_ch.tamper_pin    <= p[9];
		in_ch.wakeup_pin    <= p[8];
		in_ch.expander_pins <= p[7:0];
		in_ch.touch_active  <= active;
		in_ch.touch_sample  <= sample;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Stops offering ticks, waits for every expected event, then lets the block go idle.
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Writes the whole register set; the block must be idle when this is called.
	task automatic apply_cfg(input logic [1:0] orient, input logic [11:0] x_lo,
			input logic [11:0] x_hi, input logic [11:0] y_lo, input logic [11:0] y_hi);
		cfg_write(CFG_ORIENT, CFG_DATA_W'(orient));
		cfg_write(CFG_X_MIN, x_lo);
		cfg_write(CFG_X_MAX, x_hi);
		cfg_write(CFG_Y_MIN, y_lo);
		cfg_write(CFG_Y_MAX, y_hi);
		cfg_we <= 1'b0;
	endtask

	// Builds one random tick. Most ticks follow a realistic pattern: buttons change one at
	// a time and touches come as gestures (a run of active samples, often repeating or
	// jittering around the previous point, followed by a short release). The rest is noise
	// with every field random.
	task automatic random_tick();
		logic [23:0] s;
		logic        act;
		int          pick;
		if ($urandom_range(99) < 15) begin
			pins = 11'($urandom);
			act  = 1'($urandom_range(1));
			s    = 24'($urandom);
		end else begin
			if ($urandom_range(99) < 35) begin
				pick       = $urandom_range(10);
				pins[pick] = ~pins[pick];
			end
			if (touch_run == 0 && touch_gap == 0) begin
				touch_run = $urandom_range(2, 10);
				touch_gap = $urandom_range(1, 3);
			end
			if (touch_run > 0) begin
				act = 1'b1;
				touch_run--;
				pick = $urandom_range(99);
				if (pick < 30)
					s = last_sample;
				else if (pick < 60)
					s = last_sample ^ {12'($urandom_range(7)), 12'($urandom_range(7))};
				else
					s = 24'($urandom);
			end else begin
				act = 1'b0;
				touch_gap--;
				s = 24'($urandom);
			end
		end
		last_sample = s;
		send_tick(pins, act, s);
	endtask

	initial begin
		logic [11:0] x_lo;
		logic [11:0] x_hi;
		logic [11:0] y_lo;
		logic [11:0] y_hi;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_ORIENT;
		cfg_wdata           <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.key_pin       <= 1'b1;
		in_ch.tamper_pin    <= 1'b1;
		in_ch.wakeup_pin    <= 1'b0;
		in_ch.expander_pins <= 8'hFF;
		in_ch.touch_active  <= 1'b0;
		in_ch.touch_sample  <= '0;
		in_idle_on  = 1'b1;
		out_idle_on = 1'b1;
		hold_req    = 1'b0;
		pins        = PINS_RELEASED;
		touch_run   = 0;
		touch_gap   = 0;
		last_sample = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset calibration. Nothing pressed and no touch gives no
		// events; then every button goes down and up at once, with the ignored low
		// expander bits at both levels.
		send_tick(PINS_RELEASED, 1'b0, 24'h000000);
		send_tick(PINS_ALL_DOWN, 1'b0, 24'h000000);
		send_tick({1'b1, 1'b1, 1'b0, 8'hF8}, 1'b0, 24'h000000);
		// A touch: the first sample is dropped, then the two corners clamp to the screen
		// edges, an unchanged point gives no move, and the release reports the last point
		// together with a button press.
		send_tick(PINS_RELEASED, 1'b1, 24'hFFFFFF);
		send_tick(PINS_RELEASED, 1'b1, 24'h000FFF);
		send_tick(PINS_RELEASED, 1'b1, 24'hFFF000);
		send_tick(PINS_RELEASED, 1'b1, 24'hFFF000);
		send_tick({1'b0, 1'b1, 1'b0, 8'hFF}, 1'b0, 24'h000000);
		// Button changes on the same ticks as a dropped sample and as a touch down.
		send_tick({1'b1, 1'b1, 1'b0, 8'h7F}, 1'b1, 24'h800800);
		send_tick(PINS_RELEASED, 1'b1, 24'h800800);
		send_tick(PINS_RELEASED, 1'b0, 24'h000000);

		// Equal calibration bounds in horizontal orientation: every point scales to zero,
		// so a different sample gives no move.
		settle();
		apply_cfg(ORIENT_HORIZ, 12'd2048, 12'd2048, 12'd0, 12'd0);
		send_tick(PINS_RELEASED, 1'b1, 24'h123456);
		send_tick(PINS_RELEASED, 1'b1, 24'h123456);
		send_tick(PINS_RELEASED, 1'b1, 24'hABCDEF);
		send_tick(PINS_RELEASED, 1'b0, 24'h000000);

		// Inverted bounds in mirrored vertical orientation: negative denominators, clamped.
		settle();
		apply_cfg(ORIENT_VERT_MIRR, 12'd4095, 12'd0, 12'd4095, 12'd0);
		send_tick(PINS_RELEASED, 1'b1, 24'h000000);
		send_tick(PINS_RELEASED, 1'b1, 24'h000000);
		send_tick(PINS_RELEASED, 1'b1, 24'hFFFFFF);
		send_tick(PINS_RELEASED, 1'b0, 24'h000000);

		// Full raw range in mirrored horizontal orientation.
		settle();
		apply_cfg(ORIENT_HORIZ_MIRR, 12'd0, 12'd4095, 12'd0, 12'd4095);
		send_tick(PINS_ALL_DOWN, 1'b1, 24'h000FFF);
		send_tick(PINS_ALL_DOWN, 1'b1, 24'h000FFF);
		send_tick(PINS_RELEASED, 1'b1, 24'hFFF000);
		send_tick(PINS_RELEASED, 1'b0, 24'h000000);

		// Random part, one calibration setting per phase. Orientation walks through all four
		// values; the bounds cover reset values, full range, equal, inverted and random.
		// Phase 2 starts with a long receiver hold-off, phase 5 runs without any idling.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					x_lo = X_MIN_RST;
					x_hi = X_MAX_RST;
					y_lo = Y_MIN_RST;
					y_hi = Y_MAX_RST;
				end
				2: begin
					x_lo = 12'd0;
					x_hi = 12'd4095;
					y_lo = 12'd0;
					y_hi = 12'd4095;
				end
				3, 7: begin
					x_lo = 12'($urandom);
					x_hi = 12'($urandom);
					y_lo = 12'($urandom);
					y_hi = 12'($urandom);
				end
				4: begin
					x_lo = 12'($urandom);
					x_hi = x_lo;
					y_lo = 12'($urandom);
					y_hi = y_lo;
				end
				5: begin
					x_lo = 12'($urandom_range(2500, 4095));
					x_hi = 12'($urandom_range(0, 1500));
					y_lo = 12'($urandom_range(2500, 4095));
					y_hi = 12'($urandom_range(0, 1500));
				end
				default: begin
					x_lo = 12'($urandom_range(0, 1500));
					x_hi = 12'($urandom_range(2500, 4095));
					y_lo = 12'($urandom_range(0, 1500));
					y_hi = 12'($urandom_range(2500, 4095));
				end
			endcase
			apply_cfg(2'(ph), x_lo, x_hi, y_lo, y_hi);
			in_idle_on  = (ph != 5);
			out_idle_on = (ph != 5);
			if (ph == 2)
				hold_req = 1'b1;
			repeat (TICKS_PER_PHASE) random_tick();
		end

		// Drain: every expected event must arrive, and nothing extra may follow.
		settle();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
